>>> design/vre_pkg.sv
// ----------------------------------------------------------------------------
// vre_pkg
// Shared codes and widths for the voxel ray edit block.
// ----------------------------------------------------------------------------
package vre_pkg;

  // request codes
  localparam logic [2:0] REQ_LOAD    = 3'd0;
  localparam logic [2:0] REQ_REFRESH = 3'd1;
  localparam logic [2:0] REQ_READ    = 3'd2;
  localparam logic [2:0] REQ_PLACE   = 3'd3;
  localparam logic [2:0] REQ_REMOVE  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_OOB  = 2'd2;

  // configuration register indexes and reset values
  localparam logic [7:0] CFG_STEP_LENGTH = 8'd0;
  localparam logic [7:0] CFG_STEP_COUNT  = 8'd1;
  localparam logic [7:0] STEP_LENGTH_RST = 8'd26;
  localparam logic [7:0] STEP_COUNT_RST  = 8'd50;

  // signed cell coordinate and ray position widths
  localparam int CW = 12;
  localparam int PW = 34;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [PW-1:0] pos_t;

endpackage

>>> design/vre_req_if.sv
// ----------------------------------------------------------------------------
// vre_req_if
// Request channel: one load, edit, refresh or read item.
// ----------------------------------------------------------------------------
interface vre_req_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  req_type;
  logic        [5:0]  cell_x;
  logic        [3:0]  cell_y;
  logic        [5:0]  cell_z;
  logic        [2:0]  block_type;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] start_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  modport source (output valid, req_type, cell_x, cell_y, cell_z, block_type,
                  start_x, start_y, start_z, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, req_type, cell_x, cell_y, cell_z, block_type,
                  start_x, start_y, start_z, dir_x, dir_y, dir_z, output ready);
endinterface

>>> design/vre_res_if.sv
// ----------------------------------------------------------------------------
// vre_res_if
// Result channel: one item per request.
// ----------------------------------------------------------------------------
interface vre_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] res_x;
  logic [3:0] res_y;
  logic [5:0] res_z;
  logic [2:0] res_type;
  logic       res_visible;

  modport source (output valid, status, res_x, res_y, res_z, res_type, res_visible,
                  input ready);
  modport sink   (input valid, status, res_x, res_y, res_z, res_type, res_visible,
                  output ready);
endinterface

>>> design/vre_cfg_if.sv
// ----------------------------------------------------------------------------
// vre_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface vre_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] addr;
  logic [7:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

>>> design/vre_ram.sv
// ----------------------------------------------------------------------------
// vre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vre_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/voxel_ray_edit_with_face_culling.sv
// ----------------------------------------------------------------------------
// voxel_ray_edit_with_face_culling
// Voxel grid editor: load, refresh, read, and ray-picked place and remove
// with face-culling visibility refresh of the 27 cells around each edit.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake   | carries
//  --------+-----+-------------+-----------------------------------------
//  req     | in  | valid/ready | request type, cell, material, ray
//  res     | out | valid/ready | status, cell, material, visible bit
//  cfg     | in  | valid/ready | register index and 8-bit data
//
//  A ray steps through up to step_count samples, then an edit sweeps the
//  27 cells around it (an own read plus up to six face reads each), all
//  bound by the one RAM read port. Reset starts a clearing pass over all
//  GRID_SIDE*GRID_HEIGHT*GRID_SIDE cells (65536 by default) during which
//  no item is taken; cfg is always ready.
//  One item is in work at a time; a finished result waits in the output
//  register while the next item is taken.
// ----------------------------------------------------------------------------
module voxel_ray_edit_with_face_culling
  import vre_pkg::*;
#(
  parameter int GRID_SIDE   = 64,
  parameter int GRID_HEIGHT = 16
) (
  input logic  clk,
  input logic  rst,
  vre_req_if.sink   req,
  vre_res_if.source res,
  vre_cfg_if.sink   cfg
);

  localparam int CELLS = GRID_SIDE * GRID_HEIGHT * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(GRID_SIDE);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam coord_t SIDE_C   = CW'(GRID_SIDE);
  localparam coord_t HEIGHT_C = CW'(GRID_HEIGHT);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_FRD    = 4'd3;
  localparam logic [3:0] S_FWAIT  = 4'd4;
  localparam logic [3:0] S_RMUL   = 4'd5;
  localparam logic [3:0] S_RINIT  = 4'd6;
  localparam logic [3:0] S_RSTEP  = 4'd7;
  localparam logic [3:0] S_RCHK   = 4'd8;
  localparam logic [3:0] S_RFCELL = 4'd9;
  localparam logic [3:0] S_RFOWN  = 4'd10;
  localparam logic [3:0] S_RFFACE = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  function automatic logic in_grid(input coord_t x, input coord_t y, input coord_t z);
    return x >= 0 && x < SIDE_C && y >= 0 && y < HEIGHT_C && z >= 0 && z < SIDE_C;
  endfunction

  function automatic logic on_edge(input coord_t x, input coord_t y, input coord_t z);
    return x == 0 || x == SIDE_C - 1 || y == 0 || y == HEIGHT_C - 1 ||
           z == 0 || z == SIDE_C - 1;
  endfunction

  function automatic logic [AW-1:0] addr_of(input coord_t x, input coord_t y,
                                            input coord_t z);
    logic [AW-1:0] a;
    a = (AW'(x[XW-1:0]) * AW'(GRID_HEIGHT) + AW'(y[YW-1:0])) * AW'(GRID_SIDE)
        + AW'(z[XW-1:0]);
    return a;
  endfunction

  // control and working registers
  logic [3:0]    state;
  logic [AW-1:0] clr_addr;
  logic [7:0]    step_length;
  logic [7:0]    step_count;
  logic [7:0]    k;
  logic [2:0]    rq_type;
  logic [2:0]    rq_mat;
  coord_t        cx, cy, cz;
  logic signed [15:0] st_x, st_y, st_z;
  logic signed [15:0] dr_x, dr_y, dr_z;
  pos_t          dl_x, dl_y, dl_z;
  pos_t          pos_x, pos_y, pos_z;
  pos_t          prv_x, prv_y, prv_z;
  logic [1:0]    ox, oy, oz;
  logic          single;
  logic [2:0]    face;
  logic [2:0]    own_mat;
  logic [1:0]    r_status;
  logic [5:0]    r_x;
  logic [3:0]    r_y;
  logic [5:0]    r_z;
  logic [2:0]    r_type;
  logic          r_vis;

  // RAM port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [3:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [3:0]    mem_rdata;

  vre_ram #(.WIDTH(4), .DEPTH(CELLS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ray sample cells: floor of the Q.22 position
  coord_t hx, hy, hz, px, py, pz;
  assign hx = pos_x[PW-1:22];
  assign hy = pos_y[PW-1:22];
  assign hz = pos_z[PW-1:22];
  assign px = prv_x[PW-1:22];
  assign py = prv_y[PW-1:22];
  assign pz = prv_z[PW-1:22];

  // cell under refresh and its face neighbour
  coord_t cur_x, cur_y, cur_z, nb_x, nb_y, nb_z;
  logic [2:0] face_sel;
  assign cur_x = cx + CW'(ox) - CW'(1);
  assign cur_y = cy + CW'(oy) - CW'(1);
  assign cur_z = cz + CW'(oz) - CW'(1);
  assign face_sel = (state == S_RFOWN) ? 3'd0 : face + 3'd1;

  always_comb begin
    nb_x = cur_x;
    nb_y = cur_y;
    nb_z = cur_z;
    case (face_sel)
      3'd0:    nb_x = cur_x - CW'(1);
      3'd1:    nb_x = cur_x + CW'(1);
      3'd2:    nb_y = cur_y - CW'(1);
      3'd3:    nb_y = cur_y + CW'(1);
      3'd4:    nb_z = cur_z - CW'(1);
      default: nb_z = cur_z + CW'(1);
    endcase
  end

  // last cell of the sweep: single refresh, or the far corner of the cube
  logic nb_last;
  assign nb_last = single || (ox == 2'd2 && oy == 2'd2 && oz == 2'd2);

  logic ray_hit;
  assign ray_hit = mem_rdata[2:0] != 3'd0;

  // read address
  always_comb begin
    case (state)
      S_RSTEP:  mem_raddr = addr_of(hx, hy, hz);
      S_FRD:    mem_raddr = addr_of(cx, cy, cz);
      S_RFCELL: mem_raddr = addr_of(cur_x, cur_y, cur_z);
      default:  mem_raddr = addr_of(nb_x, nb_y, nb_z);
    endcase
  end

  // write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_of(cur_x, cur_y, cur_z);
    mem_wdata = 4'd0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_LOAD: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(cx, cy, cz);
        mem_wdata = {1'b0, rq_mat};
      end
      S_RCHK: begin
        if (ray_hit && rq_type == REQ_PLACE) begin
          mem_we    = in_grid(px, py, pz);
          mem_waddr = addr_of(px, py, pz);
          mem_wdata = {1'b1, rq_mat};
        end else if (ray_hit) begin
          mem_we    = 1'b1;
          mem_waddr = addr_of(hx, hy, hz);
        end
      end
      S_RFOWN: begin
        mem_we    = ray_hit && on_edge(cur_x, cur_y, cur_z);
        mem_wdata = {1'b1, mem_rdata[2:0]};
      end
      S_RFFACE: begin
        mem_we    = !ray_hit || face == 3'd5;
        mem_wdata = {!ray_hit, own_mat};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= STEP_LENGTH_RST;
      step_count  <= STEP_COUNT_RST;
    end else if (cfg.valid) begin
      if (cfg.addr == CFG_STEP_LENGTH) begin
        step_length <= cfg.data;
      end else if (cfg.addr == CFG_STEP_COUNT) begin
        step_count <= cfg.data;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == S_DONE && (!res.valid || res.ready)) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res.valid || res.ready)) begin
      res.status      <= r_status;
      res.res_x       <= r_x;
      res.res_y       <= r_y;
      res.res_z       <= r_z;
      res.res_type    <= r_type;
      res.res_visible <= r_vis;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          // sweep the store to air, one cell a cycle
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end

        S_IDLE: begin
          if (req.valid) begin
            rq_type <= req.req_type;
            rq_mat  <= req.block_type;
            cx      <= CW'(req.cell_x);
            cy      <= CW'(req.cell_y);
            cz      <= CW'(req.cell_z);
            st_x    <= req.start_x;
            st_y    <= req.start_y;
            st_z    <= req.start_z;
            dr_x    <= req.dir_x;
            dr_y    <= req.dir_y;
            dr_z    <= req.dir_z;
            ox      <= 2'd1;
            oy      <= 2'd1;
            oz      <= 2'd1;
            single  <= 1'b1;
            r_status <= ST_DONE;
            r_x      <= '0;
            r_y      <= '0;
            r_z      <= '0;
            r_type   <= '0;
            r_vis    <= 1'b0;
            if (req.req_type > REQ_REMOVE) begin
              state <= S_DONE;
            end else if (req.req_type >= REQ_PLACE) begin
              state <= S_RMUL;
            end else if (!in_grid(CW'(req.cell_x), CW'(req.cell_y), CW'(req.cell_z))) begin
              r_status <= ST_OOB;
              state    <= S_DONE;
            end else if (req.req_type == REQ_LOAD) begin
              state <= S_LOAD;
            end else if (req.req_type == REQ_REFRESH) begin
              state <= S_RFCELL;
            end else begin
              state <= S_FRD;
            end
          end
        end

        S_LOAD: begin
          state <= S_FRD;
        end

        S_FRD: begin
          state <= S_FWAIT;
        end

        S_FWAIT: begin
          r_status <= ST_DONE;
          r_x      <= cx[5:0];
          r_y      <= cy[3:0];
          r_z      <= cz[5:0];
          r_type   <= mem_rdata[2:0];
          r_vis    <= mem_rdata[3];
          state    <= S_DONE;
        end

        S_RMUL: begin
          // per-step position increment
          dl_x  <= PW'(dr_x * $signed({1'b0, step_length}));
          dl_y  <= PW'(dr_y * $signed({1'b0, step_length}));
          dl_z  <= PW'(dr_z * $signed({1'b0, step_length}));
          state <= S_RINIT;
        end

        S_RINIT: begin
          pos_x <= PW'(st_x) <<< 14;
          pos_y <= PW'(st_y) <<< 14;
          pos_z <= PW'(st_z) <<< 14;
          prv_x <= (PW'(st_x) <<< 14) - dl_x;
          prv_y <= (PW'(st_y) <<< 14) - dl_y;
          prv_z <= (PW'(st_z) <<< 14) - dl_z;
          k     <= '0;
          state <= S_RSTEP;
        end

        S_RSTEP: begin
          if (k == step_count) begin
            r_status <= ST_MISS;
            state    <= S_DONE;
          end else if (in_grid(hx, hy, hz)) begin
            state <= S_RCHK;
          end else begin
            pos_x <= pos_x + dl_x;
            pos_y <= pos_y + dl_y;
            pos_z <= pos_z + dl_z;
            prv_x <= prv_x + dl_x;
            prv_y <= prv_y + dl_y;
            prv_z <= prv_z + dl_z;
            k     <= k + 8'd1;
          end
        end

        S_RCHK: begin
          if (!ray_hit) begin
            pos_x <= pos_x + dl_x;
            pos_y <= pos_y + dl_y;
            pos_z <= pos_z + dl_z;
            prv_x <= prv_x + dl_x;
            prv_y <= prv_y + dl_y;
            prv_z <= prv_z + dl_z;
            k     <= k + 8'd1;
            state <= S_RSTEP;
          end else if (rq_type == REQ_PLACE && !in_grid(px, py, pz)) begin
            r_status <= ST_OOB;
            r_x      <= hx[5:0];
            r_y      <= hy[3:0];
            r_z      <= hz[5:0];
            r_type   <= mem_rdata[2:0];
            r_vis    <= mem_rdata[3];
            state    <= S_DONE;
          end else begin
            if (rq_type == REQ_PLACE) begin
              cx <= px;
              cy <= py;
              cz <= pz;
            end else begin
              cx <= hx;
              cy <= hy;
              cz <= hz;
            end
            ox     <= 2'd0;
            oy     <= 2'd0;
            oz     <= 2'd0;
            single <= 1'b0;
            state  <= S_RFCELL;
          end
        end

        default: begin
          // refresh sweep and hand-off states
          if (state == S_DONE) begin
            if (!res.valid || res.ready) begin
              state <= S_IDLE;
            end
          end else begin
            if ((state == S_RFCELL && !in_grid(cur_x, cur_y, cur_z)) ||
                (state == S_RFOWN && (!ray_hit || on_edge(cur_x, cur_y, cur_z))) ||
                (state == S_RFFACE && (!ray_hit || face == 3'd5))) begin
              // cell finished: advance to the next of the 27
              if (nb_last) begin
                state <= S_FRD;
              end else begin
                state <= S_RFCELL;
                if (oz != 2'd2) begin
                  oz <= oz + 2'd1;
                end else begin
                  oz <= 2'd0;
                  if (oy != 2'd2) begin
                    oy <= oy + 2'd1;
                  end else begin
                    oy <= 2'd0;
                    ox <= ox + 2'd1;
                  end
                end
              end
            end else if (state == S_RFCELL) begin
              state <= S_RFOWN;
            end else if (state == S_RFOWN) begin
              own_mat <= mem_rdata[2:0];
              face    <= 3'd0;
              state   <= S_RFFACE;
            end else if (state == S_RFFACE) begin
              face <= face + 3'd1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !req.ready)
    else $error("item taken during clearing pass");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RFFACE |-> face <= 3'd5)
    else $error("face index out of range");

  a_sample_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RCHK |-> k < step_count)
    else $error("ray sample beyond step count");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state) == S_DONE)
    else $error("result raised outside hand-off");
`endif

endmodule

>>> tb/vre_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vre_tb_if
// Testbench types: the expected result item; channel interfaces come from
// the design folder.
// ----------------------------------------------------------------------------
package vre_tb_pkg;
  import vre_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] x;
    logic [3:0] y;
    logic [5:0] z;
    logic [2:0] mat;
    logic       vis;
  } cell_report_t;
endpackage

>>> tb/vre_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vre_checker
// Watches the request, result and register channels, keeps its own copy of
// the voxel grid and compares each result item with the predicted one.
// ----------------------------------------------------------------------------
module vre_checker
  import vre_pkg::*;
  import vre_tb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  vre_req_if   req,
  vre_res_if   res,
  vre_cfg_if   cfg,
  output int   fail_count,
  output int   pending
);

  localparam int SIDE   = 64;
  localparam int HEIGHT = 16;

  logic [3:0]   grid [SIDE*HEIGHT*SIDE];
  logic [7:0]   step_len;
  logic [7:0]   step_num;
  cell_report_t reports_due [$];

  function automatic bit in_grid(longint x, longint y, longint z);
    return x >= 0 && x < SIDE && y >= 0 && y < HEIGHT && z >= 0 && z < SIDE;
  endfunction

  function automatic int idx(longint x, longint y, longint z);
    return int'((x * HEIGHT + y) * SIDE + z);
  endfunction

  function automatic logic [2:0] mat_of(longint x, longint y, longint z);
    return grid[idx(x, y, z)][2:0];
  endfunction

  function automatic bit exposed(longint x, longint y, longint z);
    if (x <= 0 || x >= SIDE-1 || y <= 0 || y >= HEIGHT-1 || z <= 0 || z >= SIDE-1)
      return 1;
    return mat_of(x-1, y, z) == 0 || mat_of(x+1, y, z) == 0 ||
           mat_of(x, y-1, z) == 0 || mat_of(x, y+1, z) == 0 ||
           mat_of(x, y, z-1) == 0 || mat_of(x, y, z+1) == 0;
  endfunction

  function automatic void recompute(longint x, longint y, longint z);
    logic [2:0] m;
    m = mat_of(x, y, z);
    if (m != 0) grid[idx(x, y, z)] = {exposed(x, y, z), m};
  endfunction

  function automatic void recompute_around(longint x, longint y, longint z);
    for (int a = -1; a <= 1; a++)
      for (int b = -1; b <= 1; b++)
        for (int c = -1; c <= 1; c++)
          if (in_grid(x+a, y+b, z+c)) recompute(x+a, y+b, z+c);
  endfunction

  // floor of the Q.22 sample position in whole blocks
  function automatic longint ray_cell(logic signed [15:0] s, logic signed [15:0] d,
                                      longint t);
    longint p;
    p = longint'(s) * 16384 + longint'(d) * t;
    return p >>> 22;
  endfunction

  function automatic cell_report_t make(logic [1:0] st, longint x, longint y,
                                        longint z, logic [3:0] e);
    cell_report_t r;
    r.status = st; r.x = x[5:0]; r.y = y[3:0]; r.z = z[5:0];
    r.mat = e[2:0]; r.vis = e[3];
    return r;
  endfunction

  function automatic cell_report_t apply_request();
    longint cx, cy, cz, hx, hy, hz, px, py, pz, t;
    logic [2:0] op;
    op = req.req_type;
    cx = req.cell_x; cy = req.cell_y; cz = req.cell_z;
    if (op == REQ_LOAD || op == REQ_REFRESH || op == REQ_READ) begin
      if (op == REQ_LOAD) grid[idx(cx, cy, cz)] = {1'b0, req.block_type};
      else if (op == REQ_REFRESH) recompute(cx, cy, cz);
      return make(ST_DONE, cx, cy, cz, grid[idx(cx, cy, cz)]);
    end
    if (op != REQ_PLACE && op != REQ_REMOVE) return make(ST_DONE, 0, 0, 0, 0);
    for (int k = 0; k < step_num; k++) begin
      t  = longint'(k) * step_len;
      hx = ray_cell(req.start_x, req.dir_x, t);
      hy = ray_cell(req.start_y, req.dir_y, t);
      hz = ray_cell(req.start_z, req.dir_z, t);
      if (!in_grid(hx, hy, hz) || mat_of(hx, hy, hz) == 0) continue;
      if (op == REQ_PLACE) begin
        px = ray_cell(req.start_x, req.dir_x, t - step_len);
        py = ray_cell(req.start_y, req.dir_y, t - step_len);
        pz = ray_cell(req.start_z, req.dir_z, t - step_len);
        if (!in_grid(px, py, pz)) return make(ST_OOB, hx, hy, hz, grid[idx(hx, hy, hz)]);
        grid[idx(px, py, pz)] = {1'b1, req.block_type};
        recompute_around(px, py, pz);
        return make(ST_DONE, px, py, pz, grid[idx(px, py, pz)]);
      end
      grid[idx(hx, hy, hz)] = 4'd0;
      recompute_around(hx, hy, hz);
      return make(ST_DONE, hx, hy, hz, 4'd0);
    end
    return make(ST_MISS, 0, 0, 0, 0);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = reports_due.size();

  initial begin
    fail_count = 0;
    foreach (grid[i]) grid[i] = 4'd0;
    step_len = STEP_LENGTH_RST;
    step_num = STEP_COUNT_RST;
  end

  always @(posedge clk) begin
    cell_report_t want;
    if (!rst) begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.addr == CFG_STEP_LENGTH) step_len = cfg.data;
        else if (cfg.addr == CFG_STEP_COUNT) step_num = cfg.data;
      end
      if (res.valid && res.ready) begin
        if (reports_due.size() == 0) report_mismatch("unexpected item", 1, 0);
        else begin
          want = reports_due.pop_front();
          if (res.status != want.status) report_mismatch("status", res.status, want.status);
          if (res.res_x != want.x) report_mismatch("res_x", res.res_x, want.x);
          if (res.res_y != want.y) report_mismatch("res_y", res.res_y, want.y);
          if (res.res_z != want.z) report_mismatch("res_z", res.res_z, want.z);
          if (res.res_type != want.mat) report_mismatch("res_type", res.res_type, want.mat);
          if (res.res_visible != want.vis)
            report_mismatch("res_visible", res.res_visible, want.vis);
        end
      end
      if (req.valid && req.ready) reports_due.push_back(apply_request());
    end
  end

endmodule

>>> tb/voxel_ray_edit_with_face_culling_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_edit_with_face_culling_test
// Drives loads, refreshes, reads and ray edits into the voxel block under
// bursty input and a stalling output; the checker predicts every result.
// ----------------------------------------------------------------------------
module voxel_ray_edit_with_face_culling_test;
  import vre_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  bit   long_stall = 1'b0;

  vre_req_if req ();
  vre_res_if res ();
  vre_cfg_if cfg ();

  voxel_ray_edit_with_face_culling dut (.clk(clk), .rst(rst), .req(req), .res(res),
                                        .cfg(cfg));

  vre_checker u_checker (.clk(clk), .rst(rst), .req(req), .res(res), .cfg(cfg),
                         .fail_count(fail_count), .pending(pending));

  always #1 clk = ~clk;

  // Watchdog: the clearing pass after reset and a full ray with a 27-cell
  // sweep both fit well inside this many quiet cycles.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("voxel_ray_edit_with_face_culling_test: FAIL");
      $finish;
    end
  end

  // Receiver: stall on its own pattern; one long hold-off while input piles up.
  initial begin
    int run;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall) begin
        res.ready <= 1'b0;
        repeat (3000) @(negedge clk);
        long_stall = 1'b0;
      end
      run = $urandom_range(0, 3);
      if (run == 0) res.ready <= 1'b1;
      else res.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  task automatic write_reg(logic [7:0] index, logic [7:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1; cfg.addr <= index; cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Hold the item until taken; gaps between bursts are random.
  int burst_left = 0;
  task automatic send(logic [2:0] op, logic [5:0] x, logic [3:0] y, logic [5:0] z,
                      logic [2:0] m, logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                      logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 20)) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    req.valid <= 1'b1; req.req_type <= op; req.cell_x <= x; req.cell_y <= y;
    req.cell_z <= z; req.block_type <= m; req.start_x <= sx; req.start_y <= sy;
    req.start_z <= sz; req.dir_x <= dx; req.dir_y <= dy; req.dir_z <= dz;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (burst_left == 0) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
  endtask

  task automatic send_cell(logic [2:0] op, logic [5:0] x, logic [3:0] y, logic [5:0] z,
                           logic [2:0] m);
    send(op, x, y, z, m, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom), 16'($urandom));
  endtask

  // Ray from inside the populated corner of the grid, mostly along one axis.
  task automatic send_ray(logic [2:0] op);
    logic [15:0] d [3];
    int axis;
    axis = $urandom_range(0, 2);
    foreach (d[i]) d[i] = 16'($signed($urandom_range(0, 8000)) - 4000);
    d[axis] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    send(op, 6'($urandom), 4'($urandom), 6'($urandom), 3'($urandom),
         16'($urandom_range(0, 20*256)), 16'($urandom_range(0, 15*256)),
         16'($urandom_range(0, 20*256)), d[0], d[1], d[2]);
  endtask

  task automatic drain();
    @(negedge clk);
    req.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (30000) @(posedge clk);
  endtask

  initial begin
    int pick;
    req.valid = 1'b0; req.req_type = REQ_LOAD; req.cell_x = 0; req.cell_y = 0;
    req.cell_z = 0; req.block_type = 0; req.start_x = 0; req.start_y = 0;
    req.start_z = 0; req.dir_x = 0; req.dir_y = 0; req.dir_z = 0;
    cfg.valid = 1'b0; cfg.addr = CFG_STEP_LENGTH; cfg.data = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every request, misses and out-of-bounds place.
    send_cell(REQ_LOAD, 6'd63, 4'd15, 6'd63, 3'd7);
    send_cell(REQ_READ, 6'd63, 4'd15, 6'd63, 3'd0);
    send_cell(REQ_REFRESH, 6'd63, 4'd15, 6'd63, 3'd0);
    send_cell(REQ_LOAD, 6'd0, 4'd0, 6'd0, 3'd3);
    send_cell(REQ_REFRESH, 6'd1, 4'd1, 6'd1, 3'd0);
    send_cell(REQ_LOAD, 6'd5, 4'd5, 6'd5, 3'd2);
    send_cell(REQ_REFRESH, 6'd5, 4'd5, 6'd5, 3'd0);
    send_cell(3'd5, 6'd1, 4'd1, 6'd1, 3'd1);
    send_cell(3'd7, 6'd1, 4'd1, 6'd1, 3'd1);
    // place in front of the stone at the origin: previous sample off grid
    send(REQ_PLACE, 0, 0, 0, 3'd4, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    // place against (5,5,5) from x = 2.5, then an air place
    send(REQ_PLACE, 0, 0, 0, 3'd6, 16'sd640, 16'sd1408, 16'sd1408,
         16'sd16384, 16'sd0, 16'sd0);
    send(REQ_PLACE, 0, 0, 0, 3'd0, 16'sd640, 16'sd1408, 16'sd1408,
         16'sd16384, 16'sd0, 16'sd0);
    send(REQ_REMOVE, 0, 0, 0, 0, 16'sd640, 16'sd1408, 16'sd1408, 16'sd16384, 16'sd0, 16'sd0);
    send(REQ_REMOVE, 0, 0, 0, 0, -16'sd32768, 16'sd32767, -16'sd32768,
         -16'sd16384, 16'sd16384, -16'sd16384);
    send(REQ_REMOVE, 0, 0, 0, 0, 16'sd32767, -16'sd32768, 16'sd32767, 16'hffff, 16'h8000, 0);
    drain();

    // Register sweeps, extremes first; each phase fills a block and fires rays.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(CFG_STEP_LENGTH, 8'd1); write_reg(CFG_STEP_COUNT, 8'd255); end
        1: begin write_reg(CFG_STEP_LENGTH, 8'd255); write_reg(CFG_STEP_COUNT, 8'd1); end
        2: begin write_reg(CFG_STEP_LENGTH, 8'd128); write_reg(CFG_STEP_COUNT, 8'd60); end
        3: begin write_reg(CFG_STEP_LENGTH, 8'd26); write_reg(CFG_STEP_COUNT, 8'd50); end
        4: begin write_reg(8'd2, 8'd9); write_reg(CFG_STEP_COUNT, 8'd100); end
        default: begin
          write_reg(8'($urandom_range(1, 255)), 8'd0);
          write_reg(CFG_STEP_LENGTH, 8'($urandom_range(1, 255)));
          write_reg(CFG_STEP_COUNT, 8'($urandom_range(1, 255)));
        end
      endcase
      if (phase == 2) long_stall = 1'b1;
      for (int n = 0; n < 240; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 3)
          send_cell(REQ_LOAD, 6'($urandom_range(0, 20)), 4'($urandom),
                    6'($urandom_range(0, 20)), 3'($urandom));
        else if (pick < 5) send_ray(REQ_PLACE);
        else if (pick < 7) send_ray(REQ_REMOVE);
        else if (pick == 7) send_cell(REQ_REFRESH, 6'($urandom_range(0, 21)), 4'($urandom),
                                      6'($urandom_range(0, 21)), 3'd0);
        else if (pick == 8) send_cell(REQ_READ, 6'($urandom_range(0, 21)), 4'($urandom),
                                      6'($urandom_range(0, 21)), 3'd0);
        else send_cell(3'($urandom), 6'($urandom), 4'($urandom), 6'($urandom),
                       3'($urandom));
      end
      drain();
    end

    if (fail_count == 0) $display("voxel_ray_edit_with_face_culling_test: PASS");
    else $display("voxel_ray_edit_with_face_culling_test: FAIL");
    $finish;
  end

endmodule
